// ===== src/fbm_pkg.sv =====
`default_nettype none
package fbm_pkg;

	// Map geometry.
	localparam int DIRECT_ENTRIES    = 8;
	localparam int ENTRIES_PER_INDEX = 32;
	localparam int SECTOR_BYTES      = 128;
	localparam int TOTAL_SECTORS     = 1024;

	// Field and register widths.
	localparam int SIZE_W   = 18;
	localparam int PTR_W    = 11;
	localparam int SC_W     = 11;
	localparam int SB_SHIFT = $clog2(SECTOR_BYTES);
	localparam int IDX_W    = $clog2(ENTRIES_PER_INDEX);
	localparam int SEC_W    = $clog2(TOTAL_SECTORS);
	localparam int DIR_W    = (DIRECT_ENTRIES > 1) ? $clog2(DIRECT_ENTRIES) : 1;
	localparam int N_W      = SIZE_W - SB_SHIFT + 1;
	localparam int HELD_W   = N_W + 1;
	localparam int CNT_W    = $clog2(TOTAL_SECTORS + 1);
	localparam int BM_W     = 32;
	localparam int BIT_W    = $clog2(BM_W);
	localparam int BMA_W    = SEC_W - BIT_W;
	localparam int ST_AW    = SEC_W + IDX_W;
	localparam int SGL_END  = DIRECT_ENTRIES + ENTRIES_PER_INDEX;
	localparam int MAP_LIMIT = SGL_END + ENTRIES_PER_INDEX * ENTRIES_PER_INDEX;

	typedef enum logic [1:0] {
		ACT_ALLOC = 2'd0,
		ACT_GROW  = 2'd1,
		ACT_XLATE = 2'd2,
		ACT_FREE  = 2'd3
	} act_t;

	// Datapath micro-operations, one per cycle.
	typedef enum logic [5:0] {
		OP_NONE,
		OP_LOAD,
		OP_CLR_BM,
		OP_TK_RD,
		OP_TK_ADV,
		OP_TK_SET,
		OP_REL_RD,
		OP_REL_WR,
		OP_INIT_ALLOC,
		OP_INIT_GROW,
		OP_SET_BC,
		OP_FINISH_EXT,
		OP_DIRECT_WR,
		OP_SET_SINGLE,
		OP_SET_DOUBLE,
		OP_SET_BLK_NEW,
		OP_FILL,
		OP_ST_RD_DBL,
		OP_ST_RD_SGL,
		OP_ST_RD_BLK,
		OP_BLK_FROM_RD,
		OP_WR_DBL_ENTRY,
		OP_WR_SINGLE_DATA,
		OP_WR_BLK_DATA,
		OP_CUR_INC,
		OP_INIT_FREE,
		OP_REL_DIRECT,
		OP_REL_FROM_RD,
		OP_REL_BLK,
		OP_REL_SINGLE,
		OP_REL_DOUBLE,
		OP_CLEAR_MAP,
		OP_TR_INIT,
		OP_RES_OK,
		OP_RES_FAIL,
		OP_RES_DIRECT,
		OP_RES_RD,
		OP_EMIT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		act_t act;
		logic clr_last;
		logic fits;
		logic enough_alloc;
		logic enough_grow;
		logic size_le_bc;
		logic n_le_sc;
		logic at_end;
		logic reg_direct;
		logic reg_single;
		logic single_absent;
		logic double_absent;
		logic rd_absent;
		logic fill_last;
		logic grp_last;
		logic word_full;
		logic rel_invalid;
		logic out_free;
	} dp_stat_t;

	// Sectors held by a map of n data sectors, index blocks included.
	function automatic logic [HELD_W-1:0] held_for(input logic [N_W-1:0] n);
		logic [N_W-1:0] r;
		r = n - N_W'(SGL_END);
		if (n <= N_W'(DIRECT_ENTRIES))
			return HELD_W'(n);
		else if (n <= N_W'(SGL_END))
			return HELD_W'(n) + HELD_W'(1);
		else
			return HELD_W'(n) + HELD_W'(2) + HELD_W'(r[N_W-1:IDX_W])
				+ HELD_W'(|r[IDX_W-1:0]);
	endfunction

endpackage
`default_nettype wire

// ===== src/fbm_ctrl.sv =====
`default_nettype none
module fbm_ctrl import fbm_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     req_valid,
	output logic          req_stall,
	input  wire dp_stat_t stat,
	output dp_cmd_t       cmd
);

	typedef enum logic [5:0] {
		S_CLEAR, S_IDLE, S_DECIDE,
		S_EXT, S_EXT_DW, S_SGL_NEW, S_SGL_DW, S_DBL_NEW, S_DBL_CHK,
		S_BLK_NEW, S_BLK_LINK, S_BLK_DW, S_EXT_NEXT, S_FILL,
		S_TK_RD, S_TK_CHK, S_REL_RD, S_REL_WR,
		S_FR, S_FR_DBL, S_FR_CLR, S_FR_RDREL, S_FR_BLK, S_FR_BLKRD,
		S_FR_DREL, S_FR_GRP, S_FR_NEXT,
		S_TR, S_TR_BLK, S_TR_BLKRD, S_TR_RES,
		S_OK, S_FAIL, S_EMIT
	} state_t;

	state_t state_q, state_d;
	state_t ret_q, ret_d;

	// State and return register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			ret_q   <= S_IDLE;
		end else begin
			state_q <= state_d;
			ret_q   <= ret_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);

	// Sequencing of the datapath operations.
	always_comb begin
		state_d = state_q;
		ret_d   = ret_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLR_BM;
				if (stat.clr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = OP_LOAD;
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				unique case (stat.act)
					ACT_ALLOC: begin
						if (stat.fits && stat.enough_alloc) begin
							cmd.op  = OP_INIT_ALLOC;
							state_d = S_EXT;
						end else begin
							state_d = S_FAIL;
						end
					end
					ACT_GROW: begin
						priority if (!stat.fits) begin
							state_d = S_FAIL;
						end else if (stat.size_le_bc) begin
							state_d = S_OK;
						end else if (stat.n_le_sc) begin
							cmd.op  = OP_SET_BC;
							state_d = S_OK;
						end else if (stat.enough_grow) begin
							cmd.op  = OP_INIT_GROW;
							state_d = S_EXT;
						end else begin
							state_d = S_FAIL;
						end
					end
					ACT_XLATE: begin
						cmd.op  = OP_TR_INIT;
						state_d = S_TR;
					end
					ACT_FREE: begin
						cmd.op  = OP_INIT_FREE;
						state_d = S_FR;
					end
				endcase
			end
			// Extend the map by one data sector per pass.
			S_EXT: begin
				priority if (stat.at_end) begin
					cmd.op  = OP_FINISH_EXT;
					state_d = S_OK;
				end else if (stat.reg_direct) begin
					ret_d   = S_EXT_DW;
					state_d = S_TK_RD;
				end else if (stat.reg_single) begin
					ret_d   = stat.single_absent ? S_SGL_NEW : S_SGL_DW;
					state_d = S_TK_RD;
				end else if (stat.double_absent) begin
					ret_d   = S_DBL_NEW;
					state_d = S_TK_RD;
				end else begin
					cmd.op  = OP_ST_RD_DBL;
					state_d = S_DBL_CHK;
				end
			end
			S_EXT_DW: begin
				cmd.op  = OP_DIRECT_WR;
				state_d = S_EXT_NEXT;
			end
			S_SGL_NEW: begin
				cmd.op  = OP_SET_SINGLE;
				ret_d   = S_EXT;
				state_d = S_FILL;
			end
			S_SGL_DW: begin
				cmd.op  = OP_WR_SINGLE_DATA;
				state_d = S_EXT_NEXT;
			end
			S_DBL_NEW: begin
				cmd.op  = OP_SET_DOUBLE;
				ret_d   = S_EXT;
				state_d = S_FILL;
			end
			S_DBL_CHK: begin
				if (stat.rd_absent) begin
					ret_d = S_BLK_NEW;
				end else begin
					cmd.op = OP_BLK_FROM_RD;
					ret_d  = S_BLK_DW;
				end
				state_d = S_TK_RD;
			end
			S_BLK_NEW: begin
				cmd.op  = OP_SET_BLK_NEW;
				ret_d   = S_BLK_LINK;
				state_d = S_FILL;
			end
			S_BLK_LINK: begin
				cmd.op  = OP_WR_DBL_ENTRY;
				ret_d   = S_BLK_DW;
				state_d = S_TK_RD;
			end
			S_BLK_DW: begin
				cmd.op  = OP_WR_BLK_DATA;
				state_d = S_EXT_NEXT;
			end
			S_EXT_NEXT: begin
				cmd.op  = OP_CUR_INC;
				state_d = S_EXT;
			end
			// Mark every entry of a fresh index block absent.
			S_FILL: begin
				cmd.op = OP_FILL;
				if (stat.fill_last) state_d = ret_q;
			end
			// Take the lowest free sector.
			S_TK_RD: begin
				cmd.op  = OP_TK_RD;
				state_d = S_TK_CHK;
			end
			S_TK_CHK: begin
				if (stat.word_full) begin
					cmd.op  = OP_TK_ADV;
					state_d = S_TK_RD;
				end else begin
					cmd.op  = OP_TK_SET;
					state_d = ret_q;
				end
			end
			// Release one sector.
			S_REL_RD: begin
				if (stat.rel_invalid) begin
					state_d = ret_q;
				end else begin
					cmd.op  = OP_REL_RD;
					state_d = S_REL_WR;
				end
			end
			S_REL_WR: begin
				cmd.op  = OP_REL_WR;
				state_d = ret_q;
			end
			// Free the whole map.
			S_FR: begin
				priority if (stat.at_end) begin
					cmd.op  = OP_REL_SINGLE;
					ret_d   = S_FR_DBL;
					state_d = S_REL_RD;
				end else if (stat.reg_direct) begin
					cmd.op  = OP_REL_DIRECT;
					ret_d   = S_FR_NEXT;
					state_d = S_REL_RD;
				end else if (stat.reg_single) begin
					cmd.op  = OP_ST_RD_SGL;
					state_d = S_FR_RDREL;
				end else begin
					cmd.op  = OP_ST_RD_DBL;
					state_d = S_FR_BLK;
				end
			end
			S_FR_DBL: begin
				cmd.op  = OP_REL_DOUBLE;
				ret_d   = S_FR_CLR;
				state_d = S_REL_RD;
			end
			S_FR_CLR: begin
				cmd.op  = OP_CLEAR_MAP;
				state_d = S_OK;
			end
			S_FR_RDREL: begin
				cmd.op  = OP_REL_FROM_RD;
				ret_d   = S_FR_NEXT;
				state_d = S_REL_RD;
			end
			S_FR_BLK: begin
				cmd.op  = OP_BLK_FROM_RD;
				state_d = S_FR_BLKRD;
			end
			S_FR_BLKRD: begin
				cmd.op  = OP_ST_RD_BLK;
				state_d = S_FR_DREL;
			end
			S_FR_DREL: begin
				cmd.op  = OP_REL_FROM_RD;
				ret_d   = S_FR_GRP;
				state_d = S_REL_RD;
			end
			S_FR_GRP: begin
				if (stat.grp_last) begin
					cmd.op  = OP_REL_BLK;
					ret_d   = S_FR_NEXT;
					state_d = S_REL_RD;
				end else begin
					state_d = S_FR_NEXT;
				end
			end
			S_FR_NEXT: begin
				cmd.op  = OP_CUR_INC;
				state_d = S_FR;
			end
			// Translate an offset.
			S_TR: begin
				priority if (stat.at_end) begin
					state_d = S_FAIL;
				end else if (stat.reg_direct) begin
					cmd.op  = OP_RES_DIRECT;
					state_d = S_EMIT;
				end else if (stat.reg_single) begin
					cmd.op  = OP_ST_RD_SGL;
					state_d = S_TR_RES;
				end else begin
					cmd.op  = OP_ST_RD_DBL;
					state_d = S_TR_BLK;
				end
			end
			S_TR_BLK: begin
				cmd.op  = OP_BLK_FROM_RD;
				state_d = S_TR_BLKRD;
			end
			S_TR_BLKRD: begin
				cmd.op  = OP_ST_RD_BLK;
				state_d = S_TR_RES;
			end
			S_TR_RES: begin
				cmd.op  = OP_RES_RD;
				state_d = S_EMIT;
			end
			S_OK: begin
				cmd.op  = OP_RES_OK;
				state_d = S_EMIT;
			end
			S_FAIL: begin
				cmd.op  = OP_RES_FAIL;
				state_d = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

// ===== src/fbm_dp.sv =====
`default_nettype none
module fbm_dp import fbm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire dp_cmd_t           cmd,
	output dp_stat_t               stat,
	input  wire logic [1:0]        action,
	input  wire logic [SIZE_W-1:0] size_bytes,
	input  wire logic [SIZE_W-1:0] byte_offset,
	output logic                   ok,
	output logic signed [PTR_W-1:0] sector,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall
);

	// Memories.
	logic [BM_W-1:0]  bm_mem [2**BMA_W];
	logic [PTR_W-1:0] ist_mem [2**ST_AW];

	// Map state and loop control.
	logic [SIZE_W-1:0] bc_q;
	logic [SC_W-1:0]   sc_q;
	logic [PTR_W-1:0]  single_q, double_q;
	logic [CNT_W-1:0]  free_q;
	logic [BMA_W-1:0]  hint_q, clr_q;
	logic [N_W-1:0]    cur_q, end_q;
	logic              rsp_valid_q;

	// Working data.
	act_t              act_q;
	logic [SIZE_W-1:0] size_q, off_q;
	logic [N_W-1:0]    n_q;
	logic [PTR_W-1:0]  blk_q, rel_q, ist_rd_q, res_sec_q, sector_q;
	logic [SEC_W-1:0]  idx_q, taken_q;
	logic [IDX_W-1:0]  k_q;
	logic [SEC_W-1:0]  direct_q [DIRECT_ENTRIES];
	logic [BM_W-1:0]   bm_rd_q;
	logic              res_ok_q, ok_q;

	logic [N_W-1:0]    rs, rdbl;
	logic [ST_AW-1:0]  a_sgl, a_dbl, a_blk, a_fill;
	logic [BIT_W-1:0]  zpos;
	logic [BMA_W-1:0]  rel_word;

	// Offsets within the single block and the double tree.
	assign rs     = cur_q - N_W'(DIRECT_ENTRIES);
	assign rdbl   = cur_q - N_W'(SGL_END);
	assign a_sgl  = {single_q[SEC_W-1:0], rs[IDX_W-1:0]};
	assign a_dbl  = {double_q[SEC_W-1:0], rdbl[2*IDX_W-1:IDX_W]};
	assign a_blk  = {blk_q[SEC_W-1:0], rdbl[IDX_W-1:0]};
	assign a_fill = {idx_q, k_q};
	assign rel_word = rel_q[SEC_W-1:BIT_W];

	// Lowest free bit of the bitmap word just read.
	always_comb begin
		zpos = '0;
		for (int i = BM_W - 1; i >= 0; i--) begin
			if (!bm_rd_q[i]) zpos = BIT_W'(i);
		end
	end

	// Status toward the controller.
	always_comb begin
		stat.act           = act_q;
		stat.clr_last      = (clr_q == '1);
		stat.fits          = (n_q <= N_W'(MAP_LIMIT));
		stat.enough_alloc  = (HELD_W'(free_q) >= held_for(n_q));
		stat.enough_grow   = (HELD_W'(free_q) + held_for(N_W'(sc_q)) >= held_for(n_q));
		stat.size_le_bc    = (size_q <= bc_q);
		stat.n_le_sc       = (n_q <= N_W'(sc_q));
		stat.at_end        = (cur_q >= end_q);
		stat.reg_direct    = (cur_q < N_W'(DIRECT_ENTRIES));
		stat.reg_single    = (cur_q < N_W'(SGL_END));
		stat.single_absent = single_q[PTR_W-1];
		stat.double_absent = double_q[PTR_W-1];
		stat.rd_absent     = ist_rd_q[PTR_W-1];
		stat.fill_last     = (k_q == '1);
		stat.grp_last      = (rdbl[IDX_W-1:0] == '1) || (cur_q + N_W'(1) == N_W'(sc_q));
		stat.word_full     = (&bm_rd_q);
		stat.rel_invalid   = rel_q[PTR_W-1];
		stat.out_free      = !rsp_valid_q || !rsp_stall;
	end

	// Index store port.
	logic             st_we, st_re;
	logic [ST_AW-1:0] st_addr;
	logic [PTR_W-1:0] st_wd;

	always_comb begin
		st_we   = 1'b0;
		st_re   = 1'b0;
		st_addr = a_fill;
		st_wd   = '1;
		unique case (cmd.op)
			OP_FILL: st_we = 1'b1;
			OP_WR_DBL_ENTRY: begin
				st_we = 1'b1; st_addr = a_dbl; st_wd = blk_q;
			end
			OP_WR_SINGLE_DATA: begin
				st_we = 1'b1; st_addr = a_sgl; st_wd = {1'b0, taken_q};
			end
			OP_WR_BLK_DATA: begin
				st_we = 1'b1; st_addr = a_blk; st_wd = {1'b0, taken_q};
			end
			OP_ST_RD_DBL: begin
				st_re = 1'b1; st_addr = a_dbl;
			end
			OP_ST_RD_SGL: begin
				st_re = 1'b1; st_addr = a_sgl;
			end
			OP_ST_RD_BLK: begin
				st_re = 1'b1; st_addr = a_blk;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_we) ist_mem[st_addr] <= st_wd;
		if (st_re) ist_rd_q <= ist_mem[st_addr];
	end

	// Free bitmap port.
	logic             bm_we, bm_re;
	logic [BMA_W-1:0] bm_addr;
	logic [BM_W-1:0]  bm_wd;

	always_comb begin
		bm_we   = 1'b0;
		bm_re   = 1'b0;
		bm_addr = hint_q;
		bm_wd   = '0;
		unique case (cmd.op)
			OP_CLR_BM: begin
				bm_we = 1'b1; bm_addr = clr_q;
			end
			OP_TK_RD: bm_re = 1'b1;
			OP_TK_SET: begin
				bm_we = 1'b1; bm_wd = bm_rd_q | (BM_W'(1) << zpos);
			end
			OP_REL_RD: begin
				bm_re = 1'b1; bm_addr = rel_word;
			end
			OP_REL_WR: begin
				bm_we   = 1'b1;
				bm_addr = rel_word;
				bm_wd   = bm_rd_q & ~(BM_W'(1) << rel_q[BIT_W-1:0]);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (bm_we) bm_mem[bm_addr] <= bm_wd;
		if (bm_re) bm_rd_q <= bm_mem[bm_addr];
	end

	// Map state, counters and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bc_q        <= '0;
			sc_q        <= '0;
			single_q    <= '1;
			double_q    <= '1;
			free_q      <= CNT_W'(TOTAL_SECTORS);
			hint_q      <= '0;
			clr_q       <= '0;
			cur_q       <= '0;
			end_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.op == OP_EMIT) rsp_valid_q <= 1'b1;
			else if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			unique case (cmd.op)
				OP_CLR_BM: clr_q <= clr_q + BMA_W'(1);
				OP_TK_ADV: hint_q <= hint_q + BMA_W'(1);
				OP_TK_SET: free_q <= free_q - CNT_W'(1);
				OP_REL_WR: begin
					if (bm_rd_q[rel_q[BIT_W-1:0]]) free_q <= free_q + CNT_W'(1);
					if (rel_word < hint_q) hint_q <= rel_word;
				end
				OP_INIT_ALLOC: begin
					single_q <= '1;
					double_q <= '1;
					sc_q     <= '0;
					cur_q    <= '0;
					end_q    <= n_q;
				end
				OP_INIT_GROW: begin
					cur_q <= N_W'(sc_q);
					end_q <= n_q;
				end
				OP_SET_BC: bc_q <= size_q;
				OP_FINISH_EXT: begin
					sc_q <= SC_W'(end_q);
					bc_q <= size_q;
				end
				OP_SET_SINGLE: single_q <= {1'b0, taken_q};
				OP_SET_DOUBLE: double_q <= {1'b0, taken_q};
				OP_CUR_INC: cur_q <= cur_q + N_W'(1);
				OP_INIT_FREE: begin
					cur_q <= '0;
					end_q <= N_W'(sc_q);
				end
				OP_CLEAR_MAP: begin
					bc_q     <= '0;
					sc_q     <= '0;
					single_q <= '1;
					double_q <= '1;
				end
				OP_TR_INIT: begin
					cur_q <= N_W'(off_q[SIZE_W-1:SB_SHIFT]);
					end_q <= N_W'(sc_q);
				end
				default: ;
			endcase
		end
	end

	// Working data registers.
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				act_q  <= act_t'(action);
				size_q <= size_bytes;
				off_q  <= byte_offset;
				n_q    <= N_W'((SIZE_W + 1)'(size_bytes)
					+ (SIZE_W + 1)'(SECTOR_BYTES - 1) >> SB_SHIFT);
			end
			OP_TK_SET: taken_q <= {hint_q, zpos};
			OP_DIRECT_WR: direct_q[cur_q[DIR_W-1:0]] <= taken_q;
			OP_SET_SINGLE, OP_SET_DOUBLE: begin
				idx_q <= taken_q;
				k_q   <= '0;
			end
			OP_SET_BLK_NEW: begin
				blk_q <= {1'b0, taken_q};
				idx_q <= taken_q;
				k_q   <= '0;
			end
			OP_FILL: k_q <= k_q + IDX_W'(1);
			OP_BLK_FROM_RD: blk_q <= ist_rd_q;
			OP_REL_DIRECT: rel_q <= {1'b0, direct_q[cur_q[DIR_W-1:0]]};
			OP_REL_FROM_RD: rel_q <= ist_rd_q;
			OP_REL_BLK: rel_q <= blk_q;
			OP_REL_SINGLE: rel_q <= single_q;
			OP_REL_DOUBLE: rel_q <= double_q;
			OP_RES_OK: begin
				res_ok_q  <= 1'b1;
				res_sec_q <= '1;
			end
			OP_RES_FAIL: begin
				res_ok_q  <= 1'b0;
				res_sec_q <= '1;
			end
			OP_RES_DIRECT: begin
				res_ok_q  <= 1'b1;
				res_sec_q <= {1'b0, direct_q[cur_q[DIR_W-1:0]]};
			end
			OP_RES_RD: begin
				res_ok_q  <= !ist_rd_q[PTR_W-1];
				res_sec_q <= ist_rd_q[PTR_W-1] ? '1 : ist_rd_q;
			end
			OP_EMIT: begin
				ok_q     <= res_ok_q;
				sector_q <= res_sec_q;
			end
			default: ;
		endcase
	end

	assign ok        = ok_q;
	assign sector    = sector_q;
	assign rsp_valid = rsp_valid_q;

endmodule
`default_nettype wire

// ===== src/file_block_map_allocator.sv =====
// File block map allocator: keeps one file's sector map (direct entries, a
// single-indirect and a double-indirect index block) and a free-sector bitmap.
// Request channel (req_valid/req_stall) carries action, size_bytes and
// byte_offset; a beat is taken when req_valid is high and req_stall is low.
// Response channel (rsp_valid/rsp_stall) returns ok and sector, one beat per
// request, in request order.
// Allocate, grow and free run a sequencer that works one data sector per
// pass: each sector taken reads bitmap words until one holds a free bit,
// each new index block has every entry marked absent through the single
// index store port, and each released sector is a bitmap read-modify-write.
// The bitmap read-modify-write and the single store port set its pace.
// One request is in work at a time; req_stall is low only while the
// sequencer is idle.
// After reset the bitmap is cleared one 32-bit word per cycle while
// req_stall stays high; the map comes up empty.
// A finished response sits in an output register; while rsp_stall is high it
// holds, and the next request may still be taken and worked up to its result.
`default_nettype none
module file_block_map_allocator import fbm_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [1:0]         action,
	input  wire logic [SIZE_W-1:0]  size_bytes,
	input  wire logic [SIZE_W-1:0]  byte_offset,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic                    ok,
	output logic signed [PTR_W-1:0] sector
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Sequencer.
	fbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Map registers, bitmap and index store.
	fbm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (action),
		.size_bytes  (size_bytes),
		.byte_offset (byte_offset),
		.ok          (ok),
		.sector      (sector),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall)
	);

endmodule
`default_nettype wire

// ===== test/tb_file_block_map_allocator.sv =====
`default_nettype none
module tb_file_block_map_allocator;
	import fbm_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 200000;
	localparam int DRAIN_CYCLES = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	act_t action = ACT_XLATE;
	logic [SIZE_W-1:0] size_bytes = '0;
	logic [SIZE_W-1:0] byte_offset = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic ok;
	logic signed [PTR_W-1:0] sector;

	file_block_map_allocator dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.action(action),
		.size_bytes(size_bytes),
		.byte_offset(byte_offset),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.ok(ok),
		.sector(sector)
	);

	// Free-running clock, 20 ns period.
	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	typedef struct {
		logic ok;
		logic signed [PTR_W-1:0] sector;
	} map_reply_t;

	// Shadow copy of the block map and sector bitmap.
	bit sector_used[TOTAL_SECTORS];
	int index_words[TOTAL_SECTORS*ENTRIES_PER_INDEX];
	int direct_map[DIRECT_ENTRIES];
	int file_bytes;
	int file_sectors;
	int single_blk;
	int double_blk;

	map_reply_t pending_replies[$];
	bit quiet = 1'b0;
	bit failed = 1'b0;
	int beats_sent = 0;
	int beats_checked = 0;
	int act_seen[4];
	int alloc_fails = 0;
	int xlate_hits = 0;

	function automatic int free_sectors();
		int n;
		n = 0;
		for (int i = 0; i < TOTAL_SECTORS; i++)
			if (!sector_used[i])
				n++;
		return n;
	endfunction

	function automatic int grab_sector();
		for (int i = 0; i < TOTAL_SECTORS; i++) begin
			if (!sector_used[i]) begin
				sector_used[i] = 1'b1;
				return i;
			end
		end
		return -1;
	endfunction

	function automatic int grab_index_block();
		int b;
		b = grab_sector();
		for (int k = 0; k < ENTRIES_PER_INDEX; k++)
			index_words[b*ENTRIES_PER_INDEX+k] = -1;
		return b;
	endfunction

	function automatic int sectors_held(int n);
		if (n <= DIRECT_ENTRIES)
			return n;
		if (n <= SGL_END)
			return n + 1;
		return n + 2 + (n - SGL_END + ENTRIES_PER_INDEX - 1) / ENTRIES_PER_INDEX;
	endfunction

	// Take data sectors [from, upto) in file order, index blocks just ahead.
	function automatic void map_extend(int from, int upto);
		int r;
		int blk;
		for (int c = from; c < upto; c++) begin
			if (c < DIRECT_ENTRIES) begin
				direct_map[c] = grab_sector();
			end else if (c < SGL_END) begin
				if (single_blk < 0)
					single_blk = grab_index_block();
				index_words[single_blk*ENTRIES_PER_INDEX+c-DIRECT_ENTRIES] = grab_sector();
			end else begin
				r = c - SGL_END;
				if (double_blk < 0)
					double_blk = grab_index_block();
				blk = index_words[double_blk*ENTRIES_PER_INDEX+r/ENTRIES_PER_INDEX];
				if (blk < 0) begin
					blk = grab_index_block();
					index_words[double_blk*ENTRIES_PER_INDEX+r/ENTRIES_PER_INDEX] = blk;
				end
				index_words[blk*ENTRIES_PER_INDEX+r%ENTRIES_PER_INDEX] = grab_sector();
			end
		end
	endfunction

	function automatic void drop_sector(int s);
		if (s >= 0 && s < TOTAL_SECTORS)
			sector_used[s] = 1'b0;
	endfunction

	function automatic void map_release();
		int r;
		int blk;
		for (int c = 0; c < file_sectors; c++) begin
			if (c < DIRECT_ENTRIES) begin
				drop_sector(direct_map[c]);
			end else if (c < SGL_END) begin
				drop_sector(index_words[single_blk*ENTRIES_PER_INDEX+c-DIRECT_ENTRIES]);
			end else begin
				r = c - SGL_END;
				blk = index_words[double_blk*ENTRIES_PER_INDEX+r/ENTRIES_PER_INDEX];
				drop_sector(index_words[blk*ENTRIES_PER_INDEX+r%ENTRIES_PER_INDEX]);
				if (r % ENTRIES_PER_INDEX == ENTRIES_PER_INDEX - 1 || c + 1 == file_sectors)
					drop_sector(blk);
			end
		end
		drop_sector(single_blk);
		drop_sector(double_blk);
	endfunction

	function automatic int map_lookup(int off);
		int c;
		int r;
		int blk;
		c = off / SECTOR_BYTES;
		if (c >= file_sectors || c >= MAP_LIMIT)
			return -1;
		if (c < DIRECT_ENTRIES)
			return direct_map[c];
		if (c < SGL_END)
			return index_words[single_blk*ENTRIES_PER_INDEX+c-DIRECT_ENTRIES];
		r = c - SGL_END;
		blk = index_words[double_blk*ENTRIES_PER_INDEX+r/ENTRIES_PER_INDEX];
		return index_words[blk*ENTRIES_PER_INDEX+r%ENTRIES_PER_INDEX];
	endfunction

	// Work out the reply to one request and update the shadow map.
	function automatic map_reply_t predict_map_reply(act_t a, int sz, int off);
		map_reply_t rep;
		int n;
		int s;
		n = (sz + SECTOR_BYTES - 1) / SECTOR_BYTES;
		rep.ok = 1'b0;
		rep.sector = '1;
		case (a)
			ACT_ALLOC: begin
				if (n <= MAP_LIMIT && free_sectors() >= sectors_held(n)) begin
					single_blk = -1;
					double_blk = -1;
					map_extend(0, n);
					file_sectors = n;
					file_bytes = sz;
					rep.ok = 1'b1;
				end
			end
			ACT_GROW: begin
				if (n > MAP_LIMIT) begin
					rep.ok = 1'b0;
				end else if (sz <= file_bytes) begin
					rep.ok = 1'b1;
				end else if (n <= file_sectors) begin
					file_bytes = sz;
					rep.ok = 1'b1;
				end else if (free_sectors() >= sectors_held(n) - sectors_held(file_sectors)) begin
					map_extend(file_sectors, n);
					file_sectors = n;
					file_bytes = sz;
					rep.ok = 1'b1;
				end
			end
			ACT_XLATE: begin
				s = map_lookup(off);
				if (s >= 0) begin
					rep.ok = 1'b1;
					rep.sector = PTR_W'(s);
				end
			end
			default: begin
				map_release();
				file_bytes = 0;
				file_sectors = 0;
				single_blk = -1;
				double_blk = -1;
				rep.ok = 1'b1;
			end
		endcase
		return rep;
	endfunction

	// Present one request beat and hold it until it is taken.
	task automatic send_request(act_t a, int sz, int off);
		map_reply_t rep;
		action <= a;
		size_bytes <= SIZE_W'(sz);
		byte_offset <= SIZE_W'(off);
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		rep = predict_map_reply(a, sz, off);
		pending_replies.push_back(rep);
		beats_sent++;
		act_seen[a]++;
		if (a inside {ACT_ALLOC, ACT_GROW} && !rep.ok)
			alloc_fails++;
		if (a == ACT_XLATE && rep.ok)
			xlate_hits++;
		// Random gaps between requests.
		if (!quiet && $urandom_range(0, 2) == 0) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
		end
	endtask

	// Receiver back-pressure in short bursts.
	int stall_left = 0;
	always @(posedge clk) begin
		if (quiet) begin
			rsp_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(0, 5);
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// Compare every response beat with the oldest prediction.
	always @(posedge clk) begin
		map_reply_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_replies.size() == 0) begin
				$error("response beat with no request outstanding: ok=%0b sector=%0d",
					ok, sector);
				failed = 1'b1;
			end else begin
				want = pending_replies.pop_front();
				beats_checked++;
				if (ok !== want.ok) begin
					$error("ok: expected %0b, got %0b", want.ok, ok);
					failed = 1'b1;
				end
				if (sector !== want.sector) begin
					$error("sector: expected %0d, got %0d", want.sector, sector);
					failed = 1'b1;
				end
			end
		end
	end

	// Watchdog on cycles with no beat on either channel.
	int idle_cycles = 0;
	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("** file_block_map_allocator: FAILED **");
			$finish;
		end
	end

	// Empty map, too-large sizes, each map region and its edges.
	task automatic test_map_regions();
		send_request(ACT_ALLOC, 0, 0);
		send_request(ACT_XLATE, 0, 0);
		send_request(ACT_ALLOC, 1, 0);
		send_request(ACT_XLATE, 0, 127);
		send_request(ACT_ALLOC, 262143, 0);
		send_request(ACT_GROW, 262143, 0);
		send_request(ACT_FREE, 0, 0);
		send_request(ACT_ALLOC, DIRECT_ENTRIES * SECTOR_BYTES, 0);
		send_request(ACT_GROW, DIRECT_ENTRIES * SECTOR_BYTES + 1, 0);
		send_request(ACT_GROW, SGL_END * SECTOR_BYTES, 0);
		send_request(ACT_GROW, SGL_END * SECTOR_BYTES + 1, 0);
		send_request(ACT_XLATE, 0, SGL_END * SECTOR_BYTES);
		send_request(ACT_XLATE, 0, SGL_END * SECTOR_BYTES - 1);
		send_request(ACT_XLATE, 0, 262143);
	endtask

	// Shrinking and in-place growth, then free twice.
	task automatic test_grow_and_free();
		send_request(ACT_GROW, 100, 0);
		send_request(ACT_GROW, SGL_END * SECTOR_BYTES + 100, 0);
		send_request(ACT_XLATE, 0, SGL_END * SECTOR_BYTES + 99);
		send_request(ACT_FREE, 0, 0);
		send_request(ACT_FREE, 0, 0);
	endtask

	// The largest map the size allows, then running out of sectors.
	task automatic test_exhaustion();
		send_request(ACT_ALLOC, MAP_LIMIT * SECTOR_BYTES, 0);
		send_request(ACT_ALLOC, 900 * SECTOR_BYTES, 0);
		send_request(ACT_XLATE, 0, 900 * SECTOR_BYTES - 1);
		send_request(ACT_ALLOC, 1, 0);
		send_request(ACT_ALLOC, 900 * SECTOR_BYTES, 0);
		send_request(ACT_GROW, 200 * SECTOR_BYTES, 0);
		send_request(ACT_FREE, 0, 0);
	endtask

	function automatic int pick_size();
		int w;
		w = $urandom_range(0, 19);
		if (w == 0)
			return $urandom_range(0, 262143);
		if (w < 3)
			return $urandom_range(0, 400 * SECTOR_BYTES);
		return $urandom_range(0, 80 * SECTOR_BYTES);
	endfunction

	// Mixed traffic: maps built up and then probed, with stray requests.
	task automatic test_random_traffic(int count);
		int w;
		for (int i = 0; i < count; i++) begin
			w = $urandom_range(0, 19);
			if (w < 3) begin
				if ($urandom_range(0, 9) != 0)
					send_request(ACT_FREE, $urandom, $urandom);
				send_request(ACT_ALLOC, pick_size(), $urandom);
			end else if (w < 6) begin
				send_request(ACT_GROW, file_bytes + $urandom_range(0, 30 * SECTOR_BYTES),
					$urandom);
			end else if (w < 7) begin
				send_request(ACT_GROW, pick_size(), $urandom);
			end else if (w < 17) begin
				if (file_bytes > 0 && $urandom_range(0, 4) != 0)
					send_request(ACT_XLATE, $urandom, $urandom_range(0, file_bytes - 1));
				else
					send_request(ACT_XLATE, $urandom, $urandom_range(0, 262143));
			end else begin
				send_request(ACT_FREE, $urandom, $urandom);
			end
		end
	endtask

	initial begin
		single_blk = -1;
		double_blk = -1;
		file_bytes = 0;
		file_sectors = 0;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_map_regions();
		test_grow_and_free();
		test_exhaustion();
		test_random_traffic(100);
		quiet = 1'b1;
		test_random_traffic(20);
		req_valid <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		$display("Sent %0d requests (alloc %0d, grow %0d, translate %0d, free %0d), checked %0d.",
			beats_sent, act_seen[ACT_ALLOC], act_seen[ACT_GROW], act_seen[ACT_XLATE],
			act_seen[ACT_FREE], beats_checked);
		$display("Refused allocate/grow: %0d, mapped translations: %0d.",
			alloc_fails, xlate_hits);
		if (!failed)
			$display("** file_block_map_allocator: PASSED **");
		else
			$display("** file_block_map_allocator: FAILED **");
		$finish;
	end

endmodule
`default_nettype wire
